### design/irba_pkg.sv
// ---------------------------------------------------------------------------
// irba_pkg: shared definitions for the box-average image rescaler
// Field widths, operation and register codes, and the result item type.
// ---------------------------------------------------------------------------
package irba_pkg;

  localparam int COORD_W = 12;
  localparam int STEP_W  = 21;
  localparam int DIM_W   = 10;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int PIX_W   = NCHAN * CHAN_W;
  localparam int NBANK   = 4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = STEP_W;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET   = 21'd65536;
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 10'd512;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 10'd512;

  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int PEND_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              in_range;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } res_t;

endpackage

### design/irba_ram.sv
// ---------------------------------------------------------------------------
// irba_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module irba_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### design/irba_lane.sv
// ---------------------------------------------------------------------------
// irba_lane: one color channel of the 2x2 box average
// Adds the four neighbor samples and keeps the truncated mean in a register.
// ---------------------------------------------------------------------------
module irba_lane (
  input  logic                        clk,
  input  logic [irba_pkg::CHAN_W-1:0] s0,
  input  logic [irba_pkg::CHAN_W-1:0] s1,
  input  logic [irba_pkg::CHAN_W-1:0] s2,
  input  logic [irba_pkg::CHAN_W-1:0] s3,
  output logic [irba_pkg::CHAN_W-1:0] avg_r
);
  import irba_pkg::*;

  logic [CHAN_W+1:0] sum;
  logic [CHAN_W-1:0] avg_nxt;

  always_comb begin
    sum     = (CHAN_W+2)'(s0) + (CHAN_W+2)'(s1) + (CHAN_W+2)'(s2) + (CHAN_W+2)'(s3);
    avg_nxt = sum[CHAN_W+1:2];
  end

  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
  end

endmodule

### design/irba_queue.sv
// ---------------------------------------------------------------------------
// irba_queue: merge of the channel lanes and result item queue
// Joins the lane averages with the range flag and buffers result items.
// ---------------------------------------------------------------------------
module irba_queue (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  logic [irba_pkg::NCHAN-1:0][irba_pkg::CHAN_W-1:0] avg,
  input  logic                                   in_range,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output irba_pkg::res_t                         out_item
);
  import irba_pkg::*;

  res_t            mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PEND_W-1:0] cnt_r, cnt_nxt;
  logic            pop;
  res_t            entry;

  always_comb begin
    entry.in_range = in_range;
    entry.blue     = in_range ? avg[0] : '0;
    entry.green    = in_range ? avg[1] : '0;
    entry.red      = in_range ? avg[2] : '0;
    out_valid      = (cnt_r != '0);
    out_item       = mem_r[rd_ptr_r];
    pop            = out_valid && !out_stall;
    wr_ptr_nxt     = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt     = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt        = cnt_r + PEND_W'(push) - PEND_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/image_rescale_box_average.sv
// ---------------------------------------------------------------------------
// image_rescale_box_average: backward-mapping image resize with 2x2 average
//
// Channel   Direction  Handshake          Carries
// in_       in         in_valid/in_stall  load or compute item
// out_      out        out_valid/out_stall one result item per compute
// cfg_      in         cfg_valid/cfg_ready register index and data
//
// One item is accepted per cycle unless stalled; a result passes the
// position, bank read and lane average registers. The frame store is four
// parity banks, so a 2x2 neighborhood is read at once. An eight-entry result
// queue lets input continue while results wait; in_stall rises only when
// eight compute items are queued or in flight. Reset clears control state and
// the registers; the frame store is not cleared and must be loaded before use.
// ---------------------------------------------------------------------------
module image_rescale_box_average #(
  parameter int MAX_WIDTH          = 512,
  parameter int MAX_HEIGHT         = 512,
  parameter int STEP_FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [irba_pkg::COORD_W-1:0]   in_col,
  input  logic [irba_pkg::COORD_W-1:0]   in_row,
  input  logic [irba_pkg::CHAN_W-1:0]    in_blue_in,
  input  logic [irba_pkg::CHAN_W-1:0]    in_green_in,
  input  logic [irba_pkg::CHAN_W-1:0]    in_red_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irba_pkg::CHAN_W-1:0]    out_blue_out,
  output logic [irba_pkg::CHAN_W-1:0]    out_green_out,
  output logic [irba_pkg::CHAN_W-1:0]    out_red_out,
  output logic                           out_in_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irba_pkg::CFG_DAT_W-1:0] cfg_data
);
  import irba_pkg::*;

  localparam int XB   = $clog2(MAX_WIDTH) + 1;
  localparam int YB   = $clog2(MAX_HEIGHT) + 1;
  localparam int HXB  = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
  localparam int HYB  = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
  localparam int AW   = HXB + HYB;
  localparam int BDEP = 1 << AW;
  localparam int PW   = COORD_W + STEP_W;
  localparam int SXW  = PW - STEP_FRACTION_BITS;
  localparam int LW0  = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int LW1  = ($clog2(MAX_HEIGHT + 1) > LW0) ? $clog2(MAX_HEIGHT + 1) : LW0;
  localparam int CMPW = (SXW + 1 > LW1) ? SXW + 1 : LW1;

  logic [STEP_W-1:0] step_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;

  logic              in_acc, acc_load, acc_comp, load_ok, pop;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic              v1_r, v2_r, v3_r;
  logic              rng2_r, rng3_r;
  logic [PW-1:0]     px_r, py_r, px_nxt, py_nxt;

  logic [SXW-1:0]    sx, sy;
  logic [CMPW-1:0]   sx_end, sy_end, wlim, hlim;
  logic              rng1;
  logic [XB-1:0]     sxt, sx1;
  logic [YB-1:0]     syt, sy1;

  logic [AW-1:0]     waddr;
  logic [PIX_W-1:0]  wdata;
  logic              ldv_r;
  logic [AW-1:0]     waddr_r;
  logic [PIX_W-1:0]  wdata_r;
  logic              wcol0_r, wrow0_r;
  logic [PIX_W-1:0]  rdata [NBANK];

  logic [NCHAN-1:0][CHAN_W-1:0] avg;
  res_t              q_item;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP:   step_r   <= cfg_data;
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input acceptance, store writes and the back-mapping multiply.
  always_comb begin
    in_stall = (pend_r == PEND_W'(QDEPTH));
    in_acc   = in_valid && !in_stall;
    acc_load = in_acc && (in_operation == OP_LOAD);
    acc_comp = in_acc && (in_operation == OP_COMPUTE);
    load_ok  = ((COORD_W+1)'(in_col) < (COORD_W+1)'(MAX_WIDTH)) &&
               ((COORD_W+1)'(in_row) < (COORD_W+1)'(MAX_HEIGHT));
    waddr    = {in_row[HYB:1], in_col[HXB:1]};
    wdata    = {in_red_in, in_green_in, in_blue_in};
    px_nxt   = PW'(in_col) * PW'(step_r);
    py_nxt   = PW'(in_row) * PW'(step_r);
    pop      = out_valid && !out_stall;
    pend_nxt = pend_r + PEND_W'(acc_comp) - PEND_W'(pop);
  end

  // Source position, range test and bank addressing.
  always_comb begin
    sx     = px_r[PW-1:STEP_FRACTION_BITS];
    sy     = py_r[PW-1:STEP_FRACTION_BITS];
    sx_end = CMPW'(sx) + CMPW'(1);
    sy_end = CMPW'(sy) + CMPW'(1);
    wlim   = (CMPW'(width_r) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : CMPW'(width_r);
    hlim   = (CMPW'(height_r) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : CMPW'(height_r);
    rng1   = (sx_end < wlim) && (sy_end < hlim);
    sxt    = XB'(sx);
    syt    = YB'(sy);
    sx1    = sxt + XB'(1);
    sy1    = syt + YB'(1);
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic [1:0] BK = 2'(b);
    logic [XB-1:0] xs;
    logic [YB-1:0] ys;
    logic          we;

    always_comb begin
      xs = (sxt[0] == BK[0]) ? sxt : sx1;
      ys = (syt[0] == BK[1]) ? syt : sy1;
      we = ldv_r && (wcol0_r == BK[0]) && (wrow0_r == BK[1]);
    end

    irba_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BDEP)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr_r),
      .wdata (wdata_r),
      .raddr ({ys[HYB:1], xs[HXB:1]}),
      .rdata (rdata[b])
    );
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    irba_lane u_lane (
      .clk   (clk),
      .s0    (rdata[0][c*CHAN_W +: CHAN_W]),
      .s1    (rdata[1][c*CHAN_W +: CHAN_W]),
      .s2    (rdata[2][c*CHAN_W +: CHAN_W]),
      .s3    (rdata[3][c*CHAN_W +: CHAN_W]),
      .avg_r (avg[c])
    );
  end

  // A load is written in the cycle after its acceptance, in step with the bank reads.
  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    rng2_r  <= rng1;
    rng3_r  <= rng2_r;
    waddr_r <= waddr;
    wdata_r <= wdata;
    wcol0_r <= in_col[0];
    wrow0_r <= in_row[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ldv_r  <= 1'b0;
      pend_r <= '0;
    end else begin
      v1_r   <= acc_comp;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      ldv_r  <= acc_load && load_ok;
      pend_r <= pend_nxt;
    end
  end

  irba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v3_r),
    .avg       (avg),
    .in_range  (rng3_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (q_item)
  );

  assign out_blue_out  = q_item.blue;
  assign out_green_out = q_item.green;
  assign out_red_out   = q_item.red;
  assign out_in_range  = q_item.in_range;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(QDEPTH))
    else $error("outstanding compute count exceeds queue depth");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load |=> !v1_r)
    else $error("load item entered the compute pipeline");

  a_push_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> pend_r != '0)
    else $error("result pushed without a reserved slot");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_blue_out == '0 && out_green_out == '0 && out_red_out == '0)
    else $error("out-of-range result carries nonzero channels");

endmodule
